// ----- hdl/assert_macros.svh -----
// assertion macros shared by the lru page replacement modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is held
`define LRUP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property, checked during reset as well
`define LRUP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/lrup_pkg.sv -----
// shared types and constants for the lru page replacement block
package lrup_pkg;

  localparam int CFG_W        = 4;
  localparam int FRAME_IDX_W  = 3;
  localparam int FAULT_W      = 32;
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  // controller states, one-hot
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;  // capture the input word
    logic exec;  // look up, update frames and recency, load the result
  } cmd_t;

endpackage

// ----- hdl/lrup_ctrl.sv -----
// handshake controller for the lru page replacement block
`include "assert_macros.svh"

module lrup_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  output lrup_pkg::cmd_t cmd
);
  import lrup_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // a new word is taken when idle or when the held result leaves
  assign in_tready  = (state_r == S_IDLE) || ((state_r == S_OUT) && out_tready);
  assign out_tvalid = (state_r == S_OUT);
  assign cmd.load   = in_tvalid && in_tready;
  assign cmd.exec   = (state_r == S_EXEC);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_tready) state_nxt = in_tvalid ? S_EXEC : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `LRUP_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> state_r == S_IDLE, "not idle after reset")
  `LRUP_ASSERT(a_exec_to_out, clk, rst_n, cmd.exec |=> out_tvalid, "result not presented after exec")
  `LRUP_ASSERT(a_load_then_exec, clk, rst_n, cmd.load |=> cmd.exec, "accepted word not executed")

endmodule

// ----- hdl/lrup_datapath.sv -----
// frame table, recency order, fault counter and result register
`include "assert_macros.svh"

module lrup_datapath #(
  parameter int MAX_FRAMES = 8,
  parameter int PAGE_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lrup_pkg::cmd_t                   cmd,
  input  logic [PAGE_BITS-1:0]             in_page,
  input  logic                             in_last,
  input  logic                             cfg_we,
  input  logic [lrup_pkg::CFG_W-1:0]       cfg_wdata,
  output logic                             res_hit,
  output logic [lrup_pkg::FRAME_IDX_W-1:0] res_frame,
  output logic                             res_evicted,
  output logic [PAGE_BITS-1:0]             res_evicted_page,
  output logic [lrup_pkg::FAULT_W-1:0]     res_fault_total
);
  import lrup_pkg::*;

  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W = $clog2(MAX_FRAMES + 1);

  logic [PAGE_BITS-1:0]  page_r;
  logic                  last_r;
  logic [CFG_W-1:0]      cfg_r;
  logic [CNT_W-1:0]      occ_r;
  logic [FAULT_W-1:0]    fault_r;
  logic [PAGE_BITS-1:0]  frame_page_r [MAX_FRAMES];
  logic [IDX_W-1:0]      rec_r        [MAX_FRAMES];
  logic [IDX_W-1:0]      rec_nxt      [MAX_FRAMES];

  logic [CNT_W-1:0]      limit;
  logic [MAX_FRAMES-1:0] match;
  logic [MAX_FRAMES-1:0] rec_match;
  logic [IDX_W-1:0]      hit_idx;
  logic [IDX_W-1:0]      pos;
  logic [IDX_W-1:0]      f;
  logic                  is_hit;
  logic                  is_fill;
  logic                  is_evict;
  logic [FAULT_W-1:0]    fault_nxt;
  logic [31:0]           f_ext;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  // input word capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_r <= in_page;
      last_r <= in_last;
    end
  end

  // frame limit, zero acts as one, clamped to the table size
  always_comb begin
    if (cfg_r == '0) begin
      limit = CNT_W'(1);
    end else if (32'(cfg_r) > MAX_FRAMES) begin
      limit = CNT_W'(MAX_FRAMES);
    end else begin
      limit = CNT_W'(cfg_r);
    end
  end

  // parallel compare against occupied frames
  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      match[i] = (CNT_W'(i) < occ_r) && (frame_page_r[i] == page_r);
    end
  end

  // lowest matching frame
  always_comb begin
    hit_idx = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if (match[i]) hit_idx = IDX_W'(i);
    end
  end

  assign is_hit   = |match;
  assign is_fill  = !is_hit && (occ_r < limit);
  assign is_evict = !is_hit && !is_fill;

  // frame used by this reference
  always_comb begin
    if (is_hit) begin
      f = hit_idx;
    end else if (is_fill) begin
      f = occ_r[IDX_W-1:0];
    end else begin
      f = rec_r[0];
    end
  end

  // position of the hit frame in the recency order
  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      rec_match[i] = (CNT_W'(i) < occ_r) && (rec_r[i] == hit_idx);
    end
  end

  always_comb begin
    pos = '0;
    if (is_hit) begin
      for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
        if (rec_match[i]) pos = IDX_W'(i);
      end
    end
  end

  // recency update: append on fill, remove and append on hit or eviction
  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      rec_nxt[i] = rec_r[i];
      if (is_fill) begin
        if (CNT_W'(i) == occ_r) rec_nxt[i] = f;
      end else begin
        if ((CNT_W'(i) + CNT_W'(1) < occ_r) && (IDX_W'(i) >= pos)) begin
          rec_nxt[i] = rec_r[(i + 1 < MAX_FRAMES) ? i + 1 : i];
        end
        if (CNT_W'(i) + CNT_W'(1) == occ_r) rec_nxt[i] = f;
      end
    end
  end

  // saturating fault count including this reference
  always_comb begin
    fault_nxt = fault_r;
    if (!is_hit && (fault_r != '1)) fault_nxt = fault_r + FAULT_W'(1);
  end

  // occupancy and fault counter, cleared after the last reference
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r   <= '0;
      fault_r <= '0;
    end else if (cmd.exec) begin
      if (last_r) begin
        occ_r   <= '0;
        fault_r <= '0;
      end else begin
        occ_r   <= is_fill ? occ_r + CNT_W'(1) : occ_r;
        fault_r <= fault_nxt;
      end
    end
  end

  // frame table and recency order
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (!is_hit) frame_page_r[f] <= page_r;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        rec_r[i] <= rec_nxt[i];
      end
    end
  end

  assign f_ext = 32'(f);

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_hit          <= is_hit;
      res_frame        <= f_ext[FRAME_IDX_W-1:0];
      res_evicted      <= is_evict;
      res_evicted_page <= is_evict ? frame_page_r[f] : '0;
      res_fault_total  <= fault_nxt;
    end
  end

  `LRUP_ASSERT(a_last_clears, clk, rst_n, cmd.exec && last_r |=> occ_r == '0 && fault_r == '0, "state not cleared after last reference")
  `LRUP_ASSERT(a_hit_no_evict, clk, rst_n, cmd.exec |=> !(res_hit && res_evicted), "hit and eviction together")
  `LRUP_ASSERT(a_fill_grows, clk, rst_n, cmd.exec && !last_r && is_fill |=> occ_r == $past(occ_r) + 1, "fill did not grow occupancy")
  `LRUP_ASSERT(a_miss_counts, clk, rst_n, cmd.exec && !is_hit |=> res_fault_total != '0, "miss not counted")

endmodule

// ----- hdl/lru_page_replacement.sv -----
// top level of the lru page replacement block
// an accepted word is captured, then looked up and updated, then the result is valid
// input waits until the result leaves; each lookup waits for the previous table update
// a new word is accepted in the same cycle a held result is taken
// reset: synchronous active low; clears occupancy, fault count, controller, frame limit to 8
module lru_page_replacement #(
  parameter int MAX_FRAMES = 8,
  parameter int PAGE_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // page, zero padded to whole bytes
  input  logic [((PAGE_BITS + 7) / 8) * 8-1:0] in_tdata,
  // last_reference
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // frame_index, evicted_page, fault_total, zero padded to whole bytes
  output logic [((lrup_pkg::FRAME_IDX_W + PAGE_BITS + lrup_pkg::FAULT_W + 7) / 8) * 8-1:0]
                                              out_tdata,
  // hit, evicted
  output logic [1:0]                          out_tuser,
  input  logic                                cfg_we,
  input  logic [lrup_pkg::CFG_W-1:0]          cfg_wdata
);
  import lrup_pkg::*;

  localparam int OUT_RAW_W  = FRAME_IDX_W + PAGE_BITS + FAULT_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  cmd_t                   cmd;
  logic                   res_hit;
  logic [FRAME_IDX_W-1:0] res_frame;
  logic                   res_evicted;
  logic [PAGE_BITS-1:0]   res_evicted_page;
  logic [FAULT_W-1:0]     res_fault_total;

  lrup_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  lrup_datapath #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_page          (in_tdata[PAGE_BITS-1:0]),
    .in_last          (in_tlast),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .res_hit          (res_hit),
    .res_frame        (res_frame),
    .res_evicted      (res_evicted),
    .res_evicted_page (res_evicted_page),
    .res_fault_total  (res_fault_total)
  );

  // pack the result word
  assign out_tdata = OUT_DATA_W'({res_fault_total, res_evicted_page, res_frame});
  assign out_tuser = {res_evicted, res_hit};

endmodule
